### rtl/core/pffa_pkg.sv
package pffa_pkg;

  // Default pool geometry.
  localparam int FRAME_COUNT_DEF = 128;
  localparam int PAGE_SHIFT_DEF  = 21;

  // Fixed field widths of the request and result.
  localparam int REQ_W   = 8;
  localparam int CHAIN_W = 7;
  localparam int FRAME_W = 7;
  localparam int ADDR_W  = 28;
  localparam int STAT_W  = 2;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOMEM = 2'd2;

  // One result as handed from the controller to the output stage.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] head_frame;
    logic [ADDR_W-1:0]  head_address;
  } res_t;

endpackage

### rtl/core/pffa_link_mem.sv
module pffa_link_mem
  import pffa_pkg::*;
#(
  parameter int FW = 7,
  parameter int LW = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [FW-1:0] rd_addr,
  output logic [LW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [FW-1:0] wr_addr,
  input  logic [LW-1:0] wr_data
);

  logic [LW-1:0] mem [2**FW];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/pffa_out_stage.sv
module pffa_out_stage
  import pffa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  res_t               res,
  output logic               res_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [FRAME_W-1:0] head_frame,
  output logic [ADDR_W-1:0]  head_address
);

  res_t held;

  // The register may take a new result when it is empty or being drained.
  assign res_ready = !out_valid || !out_stall;

  // Valid flag of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign status       = held.status;
  assign head_frame   = held.head_frame;
  assign head_address = held.head_address;

endmodule

### rtl/core/pffa_ctrl.sv
module pffa_ctrl
  import pffa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF,
  parameter int FW          = 7,
  parameter int LW          = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [REQ_W-1:0]   request_pages,
  input  logic [CHAIN_W-1:0] chain_head,
  output logic               rd_en,
  output logic [FW-1:0]      rd_addr,
  input  logic [LW-1:0]      rd_data,
  output logic               wr_en,
  output logic [FW-1:0]      wr_addr,
  output logic [LW-1:0]      wr_data,
  output logic               res_valid,
  output res_t               res,
  input  logic               res_ready
);

  localparam int CW   = REQ_W + LW;
  localparam int XW   = CHAIN_W + LW;
  localparam int SH_W = LW + PAGE_SHIFT + ADDR_W;
  localparam int HF_W = LW + FRAME_W;

  localparam logic [LW-1:0] NULL_LINK = LW'(FRAME_COUNT);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state, state_next;
  logic [FW-1:0]    init_idx;
  logic [LW-1:0]    free_head, free_head_next;
  logic [LW-1:0]    free_count, free_count_next;
  logic [FW-1:0]    tail, tail_next;
  logic [CW-1:0]    steps, steps_next;
  logic             op, op_next;
  logic [REQ_W-1:0] want, want_next;
  logic [FW-1:0]    chain, chain_next;
  res_t             res_next;

  logic [CW-1:0]    want_ext, count_ext, sum_ext, diff_ext;
  logic [XW-1:0]    chain_ext;
  logic [SH_W-1:0]  addr_sh;
  logic [HF_W-1:0]  frame_ext;
  logic             nx_null;
  logic             go_on;

  // Widened operands for compares and arithmetic.
  assign want_ext  = CW'(request_pages);
  assign count_ext = CW'(free_count);
  assign sum_ext   = count_ext + steps;
  assign diff_ext  = count_ext - CW'(want);
  assign chain_ext = XW'(chain_head);
  assign addr_sh   = SH_W'(free_head) << PAGE_SHIFT;
  assign frame_ext = HF_W'(free_head);
  assign nx_null   = rd_data >= NULL_LINK;

  // The walk goes on while links remain and the step bound is not reached.
  always_comb begin
    if (op == MODE_ALLOC) begin
      go_on = (steps < CW'(want)) && !nx_null;
    end else begin
      go_on = (steps < CW'(FRAME_COUNT)) && !nx_null;
    end
  end

  assign in_stall  = state != S_IDLE;
  assign res_valid = state == S_DONE;

  // Sequencer: init sweep, request intake, link walk and result handoff.
  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    free_count_next = free_count;
    tail_next       = tail;
    steps_next      = steps;
    op_next         = op;
    want_next       = want;
    chain_next      = chain;
    res_next        = res;
    rd_en           = 1'b0;
    rd_addr         = tail;
    wr_en           = 1'b0;
    wr_addr         = tail;
    wr_data         = NULL_LINK;
    unique case (state)
      S_INIT: begin
        // Link every frame to the next one; the last gets the null code.
        wr_en   = 1'b1;
        wr_addr = init_idx;
        wr_data = LW'(init_idx) + LW'(1);
        if (init_idx == FW'(FRAME_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_next    = mode;
          want_next  = request_pages;
          steps_next = CW'(1);
          res_next   = '{status: STATUS_OK, head_frame: '0, head_address: '0};
          if (mode == MODE_ALLOC) begin
            if (request_pages == '0) begin
              res_next.status = STATUS_ZERO;
              state_next      = S_DONE;
            end else if (want_ext > count_ext || free_head >= NULL_LINK) begin
              res_next.status = STATUS_NOMEM;
              state_next      = S_DONE;
            end else begin
              tail_next  = free_head[FW-1:0];
              rd_en      = 1'b1;
              rd_addr    = free_head[FW-1:0];
              state_next = S_WALK;
            end
          end else begin
            if (chain_ext >= XW'(FRAME_COUNT)) begin
              state_next = S_DONE;
            end else begin
              tail_next  = chain_ext[FW-1:0];
              chain_next = chain_ext[FW-1:0];
              rd_en      = 1'b1;
              rd_addr    = chain_ext[FW-1:0];
              state_next = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (go_on) begin
          // Step to the next frame and fetch its link.
          tail_next  = rd_data[FW-1:0];
          steps_next = steps + CW'(1);
          rd_en      = 1'b1;
          rd_addr    = rd_data[FW-1:0];
        end else if (op == MODE_ALLOC) begin
          // Detach the chain: its tail gets null, the rest becomes the list.
          wr_en                 = 1'b1;
          wr_data               = NULL_LINK;
          free_head_next        = rd_data;
          free_count_next       = diff_ext[LW-1:0];
          res_next.head_frame   = frame_ext[FRAME_W-1:0];
          res_next.head_address = addr_sh[ADDR_W-1:0];
          state_next            = S_DONE;
        end else begin
          // Splice the freed chain in front of the list.
          wr_en          = 1'b1;
          wr_data        = free_head;
          free_head_next = LW'(chain);
          if (sum_ext > CW'(FRAME_COUNT)) begin
            free_count_next = NULL_LINK;
          end else begin
            free_count_next = sum_ext[LW-1:0];
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      free_head  <= '0;
      free_count <= LW'(FRAME_COUNT);
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      free_count <= free_count_next;
      if (state == S_INIT) begin
        init_idx <= init_idx + FW'(1);
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    tail  <= tail_next;
    steps <= steps_next;
    op    <= op_next;
    want  <= want_next;
    chain <= chain_next;
    res   <= res_next;
  end

endmodule

### rtl/core/page_frame_free_list_allocator_core.sv
// Allocate: a request for N pages visits N frames; failures skip the walk.
// Free: a chain of L frames visits L frames; an out-of-range head skips the walk.
// One request is worked at a time, so the next request is taken only after the
// last result is handed on; the walk reads one link memory entry a cycle.
// After reset the link memory is swept once, one entry per frame, before the
// first request is taken. Reset is synchronous and active high.
module page_frame_free_list_allocator_core
  import pffa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [REQ_W-1:0]   request_pages,
  input  logic [CHAIN_W-1:0] chain_head,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [FRAME_W-1:0] head_frame,
  output logic [ADDR_W-1:0]  head_address
);

  localparam int FW = $clog2(FRAME_COUNT);
  localparam int LW = $clog2(FRAME_COUNT + 1);

  logic          rd_en;
  logic [FW-1:0] rd_addr;
  logic [LW-1:0] rd_data;
  logic          wr_en;
  logic [FW-1:0] wr_addr;
  logic [LW-1:0] wr_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  // Next-link memory holding the free list.
  pffa_link_mem #(
    .FW(FW),
    .LW(LW)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Request sequencer and list walker.
  pffa_ctrl #(
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT),
    .FW         (FW),
    .LW         (LW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .request_pages(request_pages),
    .chain_head   (chain_head),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  // Output register.
  pffa_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .head_frame  (head_frame),
    .head_address(head_address)
  );

endmodule
